FILE: rtl/rcm_pkg.sv
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants for the RC stick mixer
// Holds field widths, mixer mode codes, register indexes and pulse arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
package rcm_pkg;
	localparam int NumChannels = 11;
	localparam int NumAxesDef = 8;
	localparam int NumButtonsDef = 16;
	localparam int AxisW = 16;
	localparam int PulseW = 12;
	localparam int GainW = 10;
	localparam int XW = 27;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 60;

	localparam logic [2:0] ModeDirect = 3'd0;
	localparam logic [2:0] ModeAirplane = 3'd1;
	localparam logic [2:0] ModeQuad = 3'd2;
	localparam logic [2:0] ModeY6 = 3'd3;
	localparam logic [2:0] ModeVtol = 3'd4;
	localparam logic [2:0] ModeToggle = 3'd5;

	localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
	localparam logic [CfgIdxW-1:0] RegAxisMap = 3'd1;
	localparam logic [CfgIdxW-1:0] RegButtonMap = 3'd2;
	localparam logic [CfgIdxW-1:0] RegGainLow = 3'd3;
	localparam logic [CfgIdxW-1:0] RegGainHigh = 3'd4;

	localparam logic [43:0] AxisMapReset = 44'hFFF_FFFF_FFFF;
	localparam logic [54:0] ButtonMapReset = {11{5'h1F}};
	localparam logic [59:0] GainLowReset = {6{10'd256}};
	localparam logic [49:0] GainHighReset = {5{10'd256}};

	localparam logic [PulseW-1:0] PulseMin = 12'd1000;
	localparam logic [PulseW-1:0] PulseMax = 12'd2100;
	localparam logic [PulseW-1:0] PulseOn = 12'd2000;

	typedef logic signed [XW-1:0] x_t;
	typedef logic [PulseW-1:0] pulse_t;

	// Truncate a Q.22 value to an integer and clamp it to PulseMin..PulseMax.
	function automatic pulse_t sat_q22(input logic signed [47:0] v);
		logic signed [47:0] q;
		begin
			q = v >>> 22;
			if (v < 0 || q < 48'sd1000) sat_q22 = PulseMin;
			else if (q > 48'sd2100) sat_q22 = PulseMax;
			else sat_q22 = q[PulseW-1:0];
		end
	endfunction
endpackage
`default_nettype wire

FILE: rtl/rcm_lane.sv
// ----------------------------------------------------------------------------
// rcm_lane: one channel's source pick and gain multiply
// Selects an axis or a button by the channel map and scales it by the gain.
// ----------------------------------------------------------------------------
`default_nettype none
module rcm_lane #(
	parameter int NumAxes = rcm_pkg::NumAxesDef,
	parameter int NumButtons = rcm_pkg::NumButtonsDef
) (
	input  wire logic                                  clk,
	input  wire logic [8*rcm_pkg::AxisW-1:0]           axes,
	input  wire logic [15:0]                           buttons,
	input  wire logic [3:0]                            axis_sel,
	input  wire logic [4:0]                            button_sel,
	input  wire logic [rcm_pkg::GainW-1:0]             gain,
	output rcm_pkg::x_t                                x_s1
);
	import rcm_pkg::*;
	logic signed [AxisW-1:0] v;
	always_comb begin
		v = '0;
		if (axis_sel != 4'd15) begin
			if ({28'd0, axis_sel} < NumAxes && axis_sel < 4'd8)
				v = axes[axis_sel[2:0]*AxisW +: AxisW];
		end else if (button_sel != 5'd31) begin
			if ({27'd0, button_sel} < NumButtons && button_sel < 5'd16 &&
			    buttons[button_sel[3:0]])
				v = 16'sd16384;
		end
	end
	always_ff @(posedge clk) begin
		x_s1 <= XW'(v * $signed(gain));
	end
endmodule
`default_nettype wire

FILE: rtl/rcm_merge.sv
// ----------------------------------------------------------------------------
// rcm_merge: mixer stage
// Combines the eleven lane results into pulse widths for the selected mode.
// ----------------------------------------------------------------------------
`default_nettype none
module rcm_merge (
	input  wire logic [2:0]                         mode,
	input  wire rcm_pkg::x_t                        x [rcm_pkg::NumChannels],
	input  wire logic [3:0]                         latches,
	input  wire logic [3:0]                         prev_high,
	output rcm_pkg::pulse_t                         p [rcm_pkg::NumChannels],
	output logic [3:0]                              latches_nx,
	output logic [3:0]                              prev_high_nx
);
	import rcm_pkg::*;
	localparam logic signed [47:0] OneQ = 48'sd4194304;

	function automatic pulse_t centred(input logic signed [47:0] v);
		centred = sat_q22(v * 500 + OneQ * 1500);
	endfunction
	function automatic pulse_t based(input logic signed [47:0] v);
		based = sat_q22(v * 1000 + OneQ * 1000);
	endfunction
	// Exact rotor form: (500*inner + 100000*ONE)/(100*ONE), inner at 100x.
	function automatic pulse_t rotor(input x_t x0, input x_t x1, input x_t x2,
			input x_t x3, input int s0, input int s1, input int s3);
		logic signed [47:0] inner, n;
		begin
			inner = 48'(x2) * 100 + OneQ * 100 + 48'(s0 * 11) * 48'(x0)
			      + 48'(s1 * 11) * 48'(x1) + 48'(s3 * 11) * 48'(x3);
			n = inner * 5 + OneQ * 1000;
			rotor = sat_q22(n);
		end
	endfunction

	logic [3:0] hi;
	always_comb begin
		for (int k = 0; k < 4; k++) hi[k] = x[4+k] > x_t'(2097152);
		latches_nx = latches;
		prev_high_nx = prev_high;
		for (int c = 0; c < NumChannels; c++) p[c] = centred(48'(x[c]));
		case (mode)
			ModeDirect: begin
			end
			ModeAirplane: begin
				p[5] = based(48'(x[5]));
				p[9] = based(48'(x[9]));
			end
			ModeQuad: begin
				p[0] = rotor(x[0], x[1], x[2], x[3], -1, 1, -1);
				p[1] = rotor(x[0], x[1], x[2], x[3], 1, 1, 1);
				p[2] = rotor(x[0], x[1], x[2], x[3], -1, -1, 1);
				p[3] = rotor(x[0], x[1], x[2], x[3], 1, -1, -1);
				p[9] = based(48'(x[9]));
				p[10] = based(48'(x[10]));
			end
			ModeY6: begin
				p[0] = rotor(x[0], x[1], x[2], x[3], -1, 1, -1);
				p[1] = rotor(x[0], x[1], x[2], x[3], -1, 1, 1);
				p[2] = rotor(x[0], x[1], x[2], x[3], 0, -1, -1);
				p[3] = rotor(x[0], x[1], x[2], x[3], 0, -1, 1);
				p[4] = rotor(x[0], x[1], x[2], x[3], 1, 1, -1);
				p[5] = rotor(x[0], x[1], x[2], x[3], 1, 1, 1);
				p[6] = centred(-48'(x[3]));
				p[7] = based(48'(x[9]));
				p[8] = centred(48'(x[0]));
				p[9] = centred(48'(x[1]));
				p[10] = centred(48'(x[6]));
			end
			ModeVtol: begin
				p[2] = based(48'(x[2]));
				for (int k = 4; k < 8; k++) p[k] = based(48'(x[k]) + 48'(x[8]));
				p[9] = based(48'(x[9]));
			end
			ModeToggle: begin
				for (int k = 0; k < 4; k++) begin
					if (hi[k] && !prev_high[k]) latches_nx[k] = !latches[k];
					prev_high_nx[k] = hi[k];
					p[4+k] = latches_nx[k] ? PulseOn : PulseMin;
				end
				p[9] = based(48'(x[9]));
			end
			default: begin
				for (int c = 0; c < NumChannels; c++) p[c] = PulseMin;
			end
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/rc_stick_to_pwm_mixer_top.sv
// ----------------------------------------------------------------------------
// rc_stick_to_pwm_mixer_top: joystick sample to eleven RC pulse widths
// The sample passes from the lane multiply into the lane register, then
// through the mixer into the output register, as m_tvalid rises.
// One request is in flight at a time, set by holding s_tready low from
// acceptance until the result is accepted.
// Reset clears the handshake state and toggle latches and loads defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module rc_stick_to_pwm_mixer_top #(
	parameter int NumAxes = rcm_pkg::NumAxesDef,
	parameter int NumButtons = rcm_pkg::NumButtonsDef
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// axis_zero..axis_seven (16 each), button_mask (16)
	input  wire logic [143:0]                   s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// pulse_zero..pulse_ten (12 each), zero pad to 136
	output logic [135:0]                        m_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rcm_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [rcm_pkg::CfgDataW-1:0]   cfg_data
);
	import rcm_pkg::*;
	logic [2:0] mode_q;
	logic [43:0] axis_map_q;
	logic [54:0] button_map_q;
	logic [109:0] gains_q;
	logic [3:0] latch_q, prev_q, latch_nx, prev_nx;
	logic [143:0] data_q;
	logic [1:0] busy_q;
	x_t x [NumChannels];
	pulse_t p [NumChannels];
	logic [135:0] pulses;
	logic [135:0] out_q;

	assign cfg_ready = 1'b1;
	assign s_tready = busy_q == 2'd0 && !m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeDirect;
			axis_map_q <= AxisMapReset;
			button_map_q <= ButtonMapReset;
			gains_q <= {GainHighReset, GainLowReset};
		end else if (cfg_valid) begin
			case (cfg_index)
				RegMode: mode_q <= cfg_data[2:0];
				RegAxisMap: axis_map_q <= cfg_data[43:0];
				RegButtonMap: button_map_q <= cfg_data[54:0];
				RegGainLow: gains_q[59:0] <= cfg_data;
				RegGainHigh: gains_q[109:60] <= cfg_data[49:0];
				default: begin
				end
			endcase
		end
	end

	for (genvar c = 0; c < NumChannels; c++) begin : g_lane
		rcm_lane #(.NumAxes(NumAxes), .NumButtons(NumButtons)) u_lane (
			.clk(clk), .axes(data_q[127:0]), .buttons(data_q[143:128]),
			.axis_sel(axis_map_q[4*c +: 4]), .button_sel(button_map_q[5*c +: 5]),
			.gain(gains_q[GainW*c +: GainW]), .x_s1(x[c]));
	end

	rcm_merge u_merge (
		.mode(mode_q), .x(x), .latches(latch_q), .prev_high(prev_q),
		.p(p), .latches_nx(latch_nx), .prev_high_nx(prev_nx));

	always_comb begin
		pulses = '0;
		for (int c = 0; c < NumChannels; c++) pulses[PulseW*c +: PulseW] = p[c];
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) data_q <= s_tdata;
		if (busy_q == 2'd2) out_q <= pulses;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'd0;
			m_tvalid <= 1'b0;
			latch_q <= '0;
			prev_q <= '0;
		end else begin
			if (s_tvalid && s_tready) busy_q <= 2'd1;
			else if (busy_q == 2'd1) busy_q <= 2'd2;
			else if (busy_q == 2'd2) begin
				busy_q <= 2'd0;
				m_tvalid <= 1'b1;
				latch_q <= latch_nx;
				prev_q <= prev_nx;
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
		end
	end
	assign m_tdata = out_q;
endmodule
`default_nettype wire
